/* design/rfr_pkg.sv */
// shared constants and control types of the radio frame receiver
package rfr_pkg;

    // frame layout
    localparam int PAYLOAD_BYTES = 32;
    localparam int HEADER_LEN    = 11;
    localparam int CHECK_AT      = HEADER_LEN + PAYLOAD_BYTES;
    localparam int POS_W         = $clog2(CHECK_AT + 1);
    localparam int AW            = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

    localparam logic [7:0] START_BYTE = 8'h3A;

    // frame positions
    localparam logic [POS_W-1:0] POS_HUNT     = POS_W'(0);
    localparam logic [POS_W-1:0] POS_GW_LO    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_GW_HI    = POS_W'(2);
    localparam logic [POS_W-1:0] POS_REP3_LO  = POS_W'(3);
    localparam logic [POS_W-1:0] POS_REP3_HI  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_REP2_LO  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_REP2_HI  = POS_W'(6);
    localparam logic [POS_W-1:0] POS_REP1_LO  = POS_W'(7);
    localparam logic [POS_W-1:0] POS_REP1_HI  = POS_W'(8);
    localparam logic [POS_W-1:0] POS_DEV_LO   = POS_W'(9);
    localparam logic [POS_W-1:0] POS_DEV_HI   = POS_W'(10);
    localparam logic [POS_W-1:0] POS_PAY_BASE = POS_W'(HEADER_LEN);
    localparam logic [POS_W-1:0] POS_CHECK    = POS_W'(CHECK_AT);

    localparam logic [AW-1:0] LAST_IDX = AW'(PAYLOAD_BYTES - 1);

    // configuration register index (paddr[2])
    localparam logic REG_GATEWAY = 1'b0;

    // result status codes
    localparam logic STATUS_GOOD = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic             take;
        logic [POS_W-1:0] pos;
        logic             load_err;
        logic             rd_en;
        logic [AW-1:0]    rd_idx;
        logic             load_pay;
        logic             last;
    } rfr_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_start;
        logic gw_lo_match;
        logic gw_hi_match;
        logic sum_match;
        logic out_busy;
    } rfr_status_t;

endpackage

/* design/rfr_if.sv */
// byte input and result output channel interfaces
interface rfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface rfr_out_if;
    logic        valid;
    logic        ready;
    logic        frame_status;
    logic [15:0] device_address;
    logic [15:0] repeater_one;
    logic [15:0] repeater_two;
    logic [15:0] repeater_three;
    logic [7:0]  payload_byte;
    logic [4:0]  payload_index;
    logic        last_of_frame;

    modport source (
        output valid, output frame_status, output device_address, output repeater_one,
        output repeater_two, output repeater_three, output payload_byte,
        output payload_index, output last_of_frame, input ready
    );
    modport sink (
        input valid, input frame_status, input device_address, input repeater_one,
        input repeater_two, input repeater_three, input payload_byte,
        input payload_index, input last_of_frame, output ready
    );
endinterface

/* design/radio_frame_receiver.sv */
// radio frame receiver: one byte per beat in, deframed payload and error results out
// an error result is registered on the checksum beat; each payload byte of a good frame is
// read from the store (ST_READ) and then loaded into the result register (ST_LOAD, which
// waits while the output stalls); throughput: one byte per cycle, except at the checksum
// byte while the result register is held and while a frame's results are read out
// reset: rst_n asynchronous; position, sum, header words and gateway register cleared,
// payload store not cleared
module radio_frame_receiver (
    input  logic         clk,
    input  logic         rst_n,
    rfr_in_if.sink       rx,
    rfr_out_if.source    result,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    logic [15:0]          gateway_reg;
    logic                 in_ready;
    rfr_pkg::rfr_cmd_t    cmd;
    rfr_pkg::rfr_status_t status;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gateway_reg <= '0;
        end
        else if (psel && penable && pwrite && paddr[2] == rfr_pkg::REG_GATEWAY)
        begin
            gateway_reg <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == rfr_pkg::REG_GATEWAY) ? {16'd0, gateway_reg} : 32'd0;

    assign rx.ready = in_ready;

    rfr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    rfr_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_byte         (rx.rx_byte),
        .gateway_address (gateway_reg),
        .cmd             (cmd),
        .status          (status),
        .result          (result)
    );

endmodule

/* design/rfr_ctrl.sv */
// frame position tracking and payload emission sequencer
module rfr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rfr_pkg::rfr_status_t status,
    output rfr_pkg::rfr_cmd_t    cmd
);

    localparam logic [1:0] ST_RECV = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [rfr_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [rfr_pkg::AW-1:0]       idx_reg, idx_next;
    logic                         take;

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        idx_next     = idx_reg;
        in_ready     = 1'b0;
        take         = 1'b0;
        cmd.load_err = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.load_pay = 1'b0;
        cmd.last     = 1'b0;
        case (state_reg)
            ST_RECV:
            begin
                // an error result needs the output register free
                in_ready = !(pos_reg == rfr_pkg::POS_CHECK && status.out_busy);
                take     = in_valid && in_ready;
                if (take)
                begin
                    if (pos_reg == rfr_pkg::POS_HUNT)
                    begin
                        pos_next = status.is_start ? rfr_pkg::POS_GW_LO : rfr_pkg::POS_HUNT;
                    end
                    else if (pos_reg == rfr_pkg::POS_GW_LO)
                    begin
                        pos_next = status.gw_lo_match ? rfr_pkg::POS_GW_HI : rfr_pkg::POS_HUNT;
                    end
                    else if (pos_reg == rfr_pkg::POS_GW_HI)
                    begin
                        pos_next = status.gw_hi_match ? rfr_pkg::POS_REP3_LO
                                                      : rfr_pkg::POS_HUNT;
                    end
                    else if (pos_reg == rfr_pkg::POS_CHECK)
                    begin
                        pos_next = rfr_pkg::POS_HUNT;
                        if (status.sum_match)
                        begin
                            idx_next   = '0;
                            state_next = ST_READ;
                        end
                        else
                        begin
                            cmd.load_err = 1'b1;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + rfr_pkg::POS_W'(1);
                    end
                end
            end
            ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_pay = 1'b1;
                    cmd.last     = (idx_reg == rfr_pkg::LAST_IDX);
                    if (idx_reg == rfr_pkg::LAST_IDX)
                    begin
                        state_next = ST_RECV;
                    end
                    else
                    begin
                        idx_next   = idx_reg + rfr_pkg::AW'(1);
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_RECV;
            end
        endcase
        cmd.take   = take;
        cmd.pos    = pos_reg;
        cmd.rd_idx = idx_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RECV;
            pos_reg   <= rfr_pkg::POS_HUNT;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

/* design/rfr_datapath.sv */
// checksum, header capture, payload store and result register
module rfr_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           rx_byte,
    input  logic [15:0]          gateway_address,
    input  rfr_pkg::rfr_cmd_t    cmd,
    output rfr_pkg::rfr_status_t status,
    rfr_out_if.source            result
);

    logic [7:0]  sum_reg;
    logic [15:0] dev_reg;
    logic [15:0] rep1_reg;
    logic [15:0] rep2_reg;
    logic [15:0] rep3_reg;
    logic [7:0]  pay_mem [rfr_pkg::PAYLOAD_BYTES];
    logic [7:0]  rd_data_reg;
    logic [rfr_pkg::AW-1:0] wr_addr;
    logic        in_payload;

    logic        out_valid_reg;
    logic        out_status_reg;
    logic [15:0] out_dev_reg;
    logic [15:0] out_rep1_reg;
    logic [15:0] out_rep2_reg;
    logic [15:0] out_rep3_reg;
    logic [7:0]  out_byte_reg;
    logic [4:0]  out_index_reg;
    logic        out_last_reg;

    // compares for the controller
    always_comb
    begin
        status.is_start    = (rx_byte == rfr_pkg::START_BYTE);
        status.gw_lo_match = (rx_byte == gateway_address[7:0]);
        status.gw_hi_match = (rx_byte == gateway_address[15:8]);
        status.sum_match   = (rx_byte == sum_reg);
        status.out_busy    = out_valid_reg && !result.ready;
    end

    assign in_payload = (cmd.pos >= rfr_pkg::POS_PAY_BASE) && (cmd.pos < rfr_pkg::POS_CHECK);
    assign wr_addr    = rfr_pkg::AW'(cmd.pos - rfr_pkg::POS_PAY_BASE);

    // running sum and header fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            dev_reg  <= '0;
            rep1_reg <= '0;
            rep2_reg <= '0;
            rep3_reg <= '0;
        end
        else if (cmd.take)
        begin
            // sum restarts on the byte seen while hunting
            sum_reg <= ((cmd.pos == rfr_pkg::POS_HUNT) ? 8'd0 : sum_reg) + rx_byte;
            case (cmd.pos)
                rfr_pkg::POS_REP3_LO: rep3_reg[7:0]  <= rx_byte;
                rfr_pkg::POS_REP3_HI: rep3_reg[15:8] <= rx_byte;
                rfr_pkg::POS_REP2_LO: rep2_reg[7:0]  <= rx_byte;
                rfr_pkg::POS_REP2_HI: rep2_reg[15:8] <= rx_byte;
                rfr_pkg::POS_REP1_LO: rep1_reg[7:0]  <= rx_byte;
                rfr_pkg::POS_REP1_HI: rep1_reg[15:8] <= rx_byte;
                rfr_pkg::POS_DEV_LO:  dev_reg[7:0]   <= rx_byte;
                rfr_pkg::POS_DEV_HI:  dev_reg[15:8]  <= rx_byte;
                default: ;
            endcase
        end
    end

    // payload store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.take && in_payload)
        begin
            pay_mem[wr_addr] <= rx_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= pay_mem[cmd.rd_idx];
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_err || cmd.load_pay)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_err || cmd.load_pay)
        begin
            out_dev_reg  <= dev_reg;
            out_rep1_reg <= rep1_reg;
            out_rep2_reg <= rep2_reg;
            out_rep3_reg <= rep3_reg;
        end
        if (cmd.load_err)
        begin
            out_status_reg <= rfr_pkg::STATUS_BAD;
            out_byte_reg   <= 8'd0;
            out_index_reg  <= 5'd0;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.load_pay)
        begin
            out_status_reg <= rfr_pkg::STATUS_GOOD;
            out_byte_reg   <= rd_data_reg;
            out_index_reg  <= 5'(cmd.rd_idx);
            out_last_reg   <= cmd.last;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.frame_status   = out_status_reg;
    assign result.device_address = out_dev_reg;
    assign result.repeater_one   = out_rep1_reg;
    assign result.repeater_two   = out_rep2_reg;
    assign result.repeater_three = out_rep3_reg;
    assign result.payload_byte   = out_byte_reg;
    assign result.payload_index  = out_index_reg;
    assign result.last_of_frame  = out_last_reg;

endmodule

/* tb/sv/radio_frame_receiver_checker.sv */
// result checker for the radio frame receiver: deframing prediction and beat comparison
`timescale 1ns / 1ps

module radio_frame_receiver_checker (
    input  logic        clk,
    input  logic        rst_n,
    rfr_in_if           byte_ch,
    rfr_out_if          result_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatch_count,
    output int          pending_results,
    output int          results_seen
);
    import rfr_pkg::*;

    typedef struct packed {
        logic        frame_status;
        logic [15:0] device_address;
        logic [15:0] repeater_one;
        logic [15:0] repeater_two;
        logic [15:0] repeater_three;
        logic [7:0]  payload_byte;
        logic [4:0]  payload_index;
        logic        last_of_frame;
    } frame_result_t;

    // expected result beats, oldest first
    frame_result_t    frame_results_q[$];

    // shadow of the deframer state
    logic [15:0]      gateway_reg;
    logic [POS_W-1:0] position;
    logic [7:0]       byte_sum;
    logic [15:0]      device_word;
    logic [15:0]      repeater_word [3];
    logic [7:0]       payload_mem [PAYLOAD_BYTES];

    task automatic push_result(input logic status, input logic [7:0] pbyte,
                               input logic [4:0] idx, input logic last);
        frame_result_t r;
        r.frame_status   = status;
        r.device_address = device_word;
        r.repeater_one   = repeater_word[0];
        r.repeater_two   = repeater_word[1];
        r.repeater_three = repeater_word[2];
        r.payload_byte   = pbyte;
        r.payload_index  = idx;
        r.last_of_frame  = last;
        frame_results_q.push_back(r);
    endtask

    // advance the deframer by one received byte
    task automatic deframe_byte(input logic [7:0] b);
        int         slot;
        int         i;
        logic [7:0] gw_want;
        if (position == POS_HUNT)
        begin
            if (b == START_BYTE)
            begin
                byte_sum = 8'h00;
                position = POS_GW_LO;
            end
        end
        else if (position == POS_GW_LO || position == POS_GW_HI)
        begin
            gw_want  = (position == POS_GW_LO) ? gateway_reg[7:0] : gateway_reg[15:8];
            position = (b == gw_want) ? position + 1'b1 : POS_HUNT;
        end
        else if (position < POS_DEV_LO)
        begin
            // repeater three first, low byte on odd positions
            slot = 2 - (int'(position) - int'(POS_REP3_LO)) / 2;
            if (position[0])
                repeater_word[slot][7:0] = b;
            else
                repeater_word[slot][15:8] = b;
            position = position + 1'b1;
        end
        else if (position < POS_PAY_BASE)
        begin
            if (position == POS_DEV_LO)
                device_word[7:0] = b;
            else
                device_word[15:8] = b;
            position = position + 1'b1;
        end
        else if (position < POS_CHECK)
        begin
            payload_mem[position - POS_PAY_BASE] = b;
            position = position + 1'b1;
        end
        else
        begin
            // checksum byte closes the frame
            if (b == byte_sum)
            begin
                for (i = 0; i < PAYLOAD_BYTES; i++)
                    push_result(STATUS_GOOD, payload_mem[i], 5'(i), i == PAYLOAD_BYTES - 1);
            end
            else
            begin
                push_result(STATUS_BAD, 8'h00, 5'd0, 1'b1);
            end
            position = POS_HUNT;
        end
        byte_sum = byte_sum + b;
    endtask

    task automatic compare_field(input string field, input logic [15:0] want,
                                 input logic [15:0] got);
        if (want !== got)
        begin
            mismatch_count = mismatch_count + 1;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
        end
    endtask

    // outputs first, then input and config beats of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            frame_results_q.delete();
            gateway_reg      = 16'h0000;
            position         = POS_HUNT;
            byte_sum         = 8'h00;
            device_word      = 16'h0000;
            repeater_word[0] = 16'h0000;
            repeater_word[1] = 16'h0000;
            repeater_word[2] = 16'h0000;
            mismatch_count   = 0;
            pending_results  = 0;
            results_seen     = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen = results_seen + 1;
                if (frame_results_q.size() == 0)
                begin
                    mismatch_count = mismatch_count + 1;
                    $display("%0t: result beat with nothing expected, status %0h index %0h",
                             $time, result_ch.frame_status, result_ch.payload_index);
                end
                else
                begin
                    want = frame_results_q.pop_front();
                    compare_field("frame_status", want.frame_status, result_ch.frame_status);
                    compare_field("device_address", want.device_address,
                                  result_ch.device_address);
                    compare_field("repeater_one", want.repeater_one, result_ch.repeater_one);
                    compare_field("repeater_two", want.repeater_two, result_ch.repeater_two);
                    compare_field("repeater_three", want.repeater_three,
                                  result_ch.repeater_three);
                    compare_field("payload_byte", want.payload_byte, result_ch.payload_byte);
                    compare_field("payload_index", want.payload_index,
                                  result_ch.payload_index);
                    compare_field("last_of_frame", want.last_of_frame,
                                  result_ch.last_of_frame);
                end
            end
            if (byte_ch.valid && byte_ch.ready)
                deframe_byte(byte_ch.rx_byte);
            if (psel && penable && pwrite && pready && paddr[2] == REG_GATEWAY)
                gateway_reg = pwdata[15:0];
            pending_results = frame_results_q.size();
        end
    end

endmodule

/* tb/sv/radio_frame_receiver_tb.sv */
// testbench top for the radio frame receiver: clock, reset, frame stimulus and verdict
`timescale 1ns / 1ps

module radio_frame_receiver_tb;
    import rfr_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE       = 8;
    localparam int TOTAL_BYTES  = 270;
    localparam int PHASES       = 4;

    typedef enum int {
        FRAME_GOOD,
        FRAME_BAD_SUM,
        FRAME_GW_LO_MISS,
        FRAME_GW_HI_MISS
    } frame_kind_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          mismatch_count;
    int          pending_results;
    int          results_seen;
    int          cycle_count;
    int          bytes_sent;
    int          good_frames;
    int          bad_frames;
    int          dropped_frames;
    logic        gaps_on;
    logic        hold_req;
    logic [15:0] gateway_now;
    logic [7:0]  frame_payload [PAYLOAD_BYTES];

    rfr_in_if  byte_ch ();
    rfr_out_if result_ch ();

    radio_frame_receiver dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (byte_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    radio_frame_receiver_checker frame_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .byte_ch         (byte_ch),
        .result_ch       (result_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_seen    (results_seen)
    );

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // one byte beat; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_ch.valid   <= 1'b1;
        byte_ch.rx_byte <= b;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        @(negedge clk);
        bytes_sent++;
    endtask

    // build a frame around frame_payload, possibly broken, and send it
    task automatic send_frame(input frame_kind_t kind, input logic [15:0] dev,
                              input logic [15:0] rep1, input logic [15:0] rep2,
                              input logic [15:0] rep3);
        logic [7:0] fb [CHECK_AT + 1];
        logic [7:0] sum;
        int         len;
        int         i;
        fb[0]  = START_BYTE;
        fb[1]  = gateway_now[7:0];
        fb[2]  = gateway_now[15:8];
        fb[3]  = rep3[7:0];
        fb[4]  = rep3[15:8];
        fb[5]  = rep2[7:0];
        fb[6]  = rep2[15:8];
        fb[7]  = rep1[7:0];
        fb[8]  = rep1[15:8];
        fb[9]  = dev[7:0];
        fb[10] = dev[15:8];
        sum    = 8'h00;
        for (i = 0; i < CHECK_AT; i++)
        begin
            if (i >= HEADER_LEN)
                fb[i] = frame_payload[i - HEADER_LEN];
            sum = sum + fb[i];
        end
        fb[CHECK_AT] = sum;
        len          = CHECK_AT + 1;
        case (kind)
            FRAME_BAD_SUM:
            begin
                fb[CHECK_AT] = sum + 8'($urandom_range(1, 255));
                bad_frames++;
            end
            FRAME_GW_LO_MISS:
            begin
                fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
                len   = 2;
                dropped_frames++;
            end
            FRAME_GW_HI_MISS:
            begin
                fb[2] = fb[2] ^ 8'($urandom_range(1, 255));
                len   = 3;
                dropped_frames++;
            end
            default:
                good_frames++;
        endcase
        for (i = 0; i < len; i++)
            send_byte(fb[i]);
    endtask

    // stop offering and wait until every expected beat is out
    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // register write with a setup phase and an access phase
    task automatic write_gateway(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_GATEWAY, 2'b00};
        pwdata  <= {16'h0000, value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        gateway_now = value;
    endtask

    function automatic logic [15:0] header_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        result_ch.ready = 1'b0;
        hold_req        = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                gap = gaps_on ? $urandom_range(0, 9) : 0;
                if (gap > 0)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // stimulus
    initial
    begin
        logic [15:0] gw_values [PHASES];
        logic [7:0]  b;
        int          phase;
        int          phase_end;
        int          i;
        byte_ch.valid   = 1'b0;
        byte_ch.rx_byte = 8'h00;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = 3'b000;
        pwdata          = 32'h0;
        rst_n           = 1'b0;
        cycle_count     = 0;
        bytes_sent      = 0;
        good_frames     = 0;
        bad_frames      = 0;
        dropped_frames  = 0;
        gaps_on         = 1'b1;
        gateway_now     = 16'h0000;
        gw_values[0]    = 16'hFFFF;
        gw_values[1]    = 16'h3A3A;
        gw_values[2]    = 16'($urandom_range(0, 65535));
        gw_values[3]    = 16'h0000;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: zero gateway, bytes ignored while hunting
        write_gateway(16'h0000);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_BYTE + 8'd1);

        // good frame with all-ones header and extreme payload bytes
        for (i = 0; i < PAYLOAD_BYTES; i++)
            frame_payload[i] = 8'($urandom_range(0, 255));
        frame_payload[0]                 = 8'h00;
        frame_payload[5]                 = START_BYTE;
        frame_payload[PAYLOAD_BYTES - 1] = 8'hFF;
        send_frame(FRAME_GOOD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // checksum mismatch carries the failed frame's header
        send_frame(FRAME_BAD_SUM, 16'h1234, 16'h0000, 16'hA55A, 16'h0000);

        // gateway mismatch on either byte drops the frame
        send_frame(FRAME_GW_LO_MISS, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_frame(FRAME_GW_HI_MISS, 16'h0000, 16'h0000, 16'h0000, 16'h0000);

        // start byte as the mismatching gateway byte must not restart the frame
        for (i = 0; i < PAYLOAD_BYTES; i++)
            frame_payload[i] = 8'h55;
        send_byte(START_BYTE);
        send_frame(FRAME_GOOD, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

        // start bytes inside the header are plain data
        send_frame(FRAME_GOOD, 16'h3A3A, 16'h003A, 16'h3A3A, 16'h3A00);
        drain_results();

        // random frames under several gateway settings, at least one pick per setting
        for (phase = 0; phase < PHASES; phase++)
        begin
            write_gateway(gw_values[phase]);
            gaps_on   = (phase != 1);
            phase_end = (TOTAL_BYTES * (phase + 1)) / PHASES;
            if (phase == 2)
            begin
                // long result hold-off while frames keep coming
                for (i = 0; i < PAYLOAD_BYTES; i++)
                    frame_payload[i] = 8'($urandom_range(0, 255));
                hold_req = 1'b1;
                send_frame(FRAME_GOOD, header_word(), header_word(), header_word(),
                           header_word());
            end
            do
            begin
                for (i = 0; i < PAYLOAD_BYTES; i++)
                    frame_payload[i] = ($urandom_range(0, 7) == 0) ? START_BYTE
                                                                  : 8'($urandom_range(0, 255));
                case ($urandom_range(0, 9))
                    0:
                    begin
                        // line noise, never a start byte
                        repeat ($urandom_range(1, 3))
                        begin
                            b = 8'($urandom_range(0, 255));
                            if (b == START_BYTE)
                                b = b + 8'd1;
                            send_byte(b);
                        end
                    end
                    1:
                    begin
                        // lone start byte followed by a wrong gateway byte
                        send_byte(START_BYTE);
                        send_byte(gateway_now[7:0] ^ 8'($urandom_range(1, 255)));
                    end
                    2:
                        send_frame(FRAME_BAD_SUM, header_word(), header_word(), header_word(),
                                   header_word());
                    3:
                        send_frame(FRAME_GW_LO_MISS, header_word(), header_word(),
                                   header_word(), header_word());
                    4:
                        send_frame(FRAME_GW_HI_MISS, header_word(), header_word(),
                                   header_word(), header_word());
                    default:
                        send_frame(FRAME_GOOD, header_word(), header_word(), header_word(),
                                   header_word());
                endcase
            end
            while (bytes_sent < phase_end);
            drain_results();
        end

        // final drain and verdict
        repeat (20) @(posedge clk);
        $display("Sent %0d bytes: %0d well-formed, %0d bad-checksum, %0d gateway-dropped frames",
                 bytes_sent, good_frames, bad_frames, dropped_frames);
        $display("Checked %0d result beats over %0d gateway settings plus reset value",
                 results_seen, PHASES);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
